>>> rtl/core/emt_pkg.sv
package emt_pkg;

    // table size and derived widths
    localparam int MAX_EXTENTS = 64;
    localparam int IDX_W       = $clog2(MAX_EXTENTS);
    localparam int CNT_W       = $clog2(MAX_EXTENTS + 1);
    // running block count before an extent never exceeds MAX_EXTENTS * (2^24 - 1)
    localparam int BEF_W       = $clog2(MAX_EXTENTS) + 24;

    // fixed field widths
    localparam int OP_W     = 2;
    localparam int BLK_W    = 32;
    localparam int LEN_W    = 24;
    localparam int OFS_W    = 40;
    localparam int SHIFT_W  = 5;
    localparam int STATUS_W = 3;
    localparam int TOTAL_W  = 7;

    localparam logic [SHIFT_W-1:0] SHIFT_RESET = 5'd12;

    typedef enum logic [OP_W-1:0] {
        OP_APPEND = 2'd0,
        OP_LOOKUP = 2'd1,
        OP_CLEAR  = 2'd2
    } t_op;

    localparam logic [STATUS_W-1:0] ST_NEW    = 3'd0;
    localparam logic [STATUS_W-1:0] ST_MERGED = 3'd1;
    localparam logic [STATUS_W-1:0] ST_FULL   = 3'd2;
    localparam logic [STATUS_W-1:0] ST_FOUND  = 3'd3;
    localparam logic [STATUS_W-1:0] ST_NONE   = 3'd4;

    // one extent as held in a cell
    typedef struct packed {
        logic [BLK_W-1:0] start;
        logic [LEN_W-1:0] len;
    } t_ext;

    // lookup wavefront handed from cell to cell
    typedef struct packed {
        logic [OFS_W-1:0] index;
        logic [BEF_W-1:0] passed;
        logic [CNT_W-1:0] remaining;
        logic             found;
        logic [BLK_W-1:0] phys;
    } t_token;

endpackage

>>> rtl/core/extent_map_translate.sv
// Extent map translator. Holds a file's extent list of up to MAX_EXTENTS
// (start block, block count) fragments in a row of cells, one extent per cell.
// Append, clear and unknown ops have their result ready in the cycle after
// the transfer in; a lookup launches a wavefront that steps through one cell
// per clock, so its result waits on the length of the cell row. One item is
// in flight at a time: the input is ready again once the result transfer has
// gone out.
// block_shift may be written through i_cfg_we / i_cfg_wdata while idle.
module extent_map_translate import emt_pkg::*; (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_cfg_we,
    input  logic [SHIFT_W-1:0]  i_cfg_wdata,
    input  logic                i_in_valid,
    output logic                o_in_ready,
    input  logic [OP_W-1:0]     i_op,
    input  logic [BLK_W-1:0]    i_start_block,
    input  logic [LEN_W-1:0]    i_run_length,
    input  logic [OFS_W-1:0]    i_byte_offset,
    output logic                o_out_valid,
    input  logic                i_out_ready,
    output logic [STATUS_W-1:0] o_status,
    output logic [BLK_W-1:0]    o_physical_block,
    output logic [TOTAL_W-1:0]  o_extent_total,
    output logic [BLK_W-1:0]    o_block_total
);

    typedef enum logic [2:0] {
        S_IDLE = 3'b001,
        S_SCAN = 3'b010,
        S_OUT  = 3'b100
    } t_state;

    t_state               r_state, n_state;
    logic [SHIFT_W-1:0]   r_shift;
    logic [CNT_W-1:0]     r_used, n_used;
    logic [BLK_W-1:0]     r_sum, n_sum;
    logic [BLK_W-1:0]     r_last_start, n_last_start;
    logic [LEN_W-1:0]     r_last_len, n_last_len;
    logic [OFS_W-1:0]     r_index, n_index;
    logic [CNT_W-1:0]     r_cnt, n_cnt;
    logic [STATUS_W-1:0]  r_status, n_status;
    logic [BLK_W-1:0]     r_phys, n_phys;

    logic                 in_xfer;
    logic [BLK_W-1:0]     last_end;
    logic [LEN_W:0]       merged;
    logic                 can_merge;
    logic                 wr_en;
    logic [CNT_W-1:0]     wr_slot;
    logic [IDX_W-1:0]     wr_addr;
    t_ext                 wr_ext;
    t_token               tok [MAX_EXTENTS+1];

    assign in_xfer = i_in_valid && o_in_ready;

    // merge check against the cached last extent
    assign last_end  = r_last_start + BLK_W'(r_last_len);
    assign merged    = {1'b0, r_last_len} + {1'b0, i_run_length};
    assign can_merge = (r_used != '0) && (last_end == i_start_block) && !merged[LEN_W];
    assign wr_addr   = wr_slot[IDX_W-1:0];

    // wavefront enters the first cell with the whole table still to scan
    assign tok[0] = {r_index, BEF_W'(0), r_used, 1'b0, BLK_W'(0)};

    for (genvar g = 0; g < MAX_EXTENTS; g++) begin : g_cell
        emt_cell u_cell (
            .i_clk (i_clk),
            .i_we  (wr_en && (wr_addr == IDX_W'(g))),
            .i_wr  (wr_ext),
            .i_tok (tok[g]),
            .o_tok (tok[g+1])
        );
    end

    always_comb begin
        n_state      = r_state;
        n_used       = r_used;
        n_sum        = r_sum;
        n_last_start = r_last_start;
        n_last_len   = r_last_len;
        n_index      = r_index;
        n_cnt        = r_cnt;
        n_status     = r_status;
        n_phys       = r_phys;
        wr_en        = 1'b0;
        wr_slot      = r_used;
        wr_ext.start = i_start_block;
        wr_ext.len   = i_run_length;

        case (r_state)
            S_IDLE: begin
                if (in_xfer) begin
                    n_phys  = '0;
                    n_state = S_OUT;
                    case (i_op)
                        OP_APPEND: begin
                            if (can_merge) begin
                                // grow the last extent in place
                                wr_en        = 1'b1;
                                wr_slot      = r_used - CNT_W'(1);
                                wr_ext.start = r_last_start;
                                wr_ext.len   = merged[LEN_W-1:0];
                                n_last_len   = merged[LEN_W-1:0];
                                n_sum        = r_sum + BLK_W'(i_run_length);
                                n_status     = ST_MERGED;
                            end else if (r_used >= CNT_W'(MAX_EXTENTS)) begin
                                n_status = ST_FULL;
                            end else begin
                                wr_en        = 1'b1;
                                n_last_start = i_start_block;
                                n_last_len   = i_run_length;
                                n_used       = r_used + CNT_W'(1);
                                n_sum        = r_sum + BLK_W'(i_run_length);
                                n_status     = ST_NEW;
                            end
                        end
                        OP_LOOKUP: begin
                            n_index = i_byte_offset >> r_shift;
                            n_cnt   = '0;
                            n_state = S_SCAN;
                        end
                        OP_CLEAR: begin
                            n_used   = '0;
                            n_sum    = '0;
                            n_status = ST_NONE;
                        end
                        default: begin
                            n_status = ST_NONE;
                        end
                    endcase
                end
            end
            S_SCAN: begin
                // last cell holds the finished wavefront once it has passed every cell
                if (r_cnt == CNT_W'(MAX_EXTENTS)) begin
                    n_status = tok[MAX_EXTENTS].found ? ST_FOUND : ST_NONE;
                    n_phys   = tok[MAX_EXTENTS].found ? tok[MAX_EXTENTS].phys : '0;
                    n_state  = S_OUT;
                end else begin
                    n_cnt = r_cnt + CNT_W'(1);
                end
            end
            S_OUT: begin
                if (i_out_ready) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_shift <= SHIFT_RESET;
            r_used  <= '0;
            r_sum   <= '0;
            r_cnt   <= '0;
        end else begin
            r_state <= n_state;
            if (i_cfg_we) begin
                r_shift <= i_cfg_wdata;
            end
            r_used  <= n_used;
            r_sum   <= n_sum;
            r_cnt   <= n_cnt;
        end
    end

    // payload, no reset needed
    always_ff @(posedge i_clk) begin
        r_last_start <= n_last_start;
        r_last_len   <= n_last_len;
        r_index      <= n_index;
        r_status     <= n_status;
        r_phys       <= n_phys;
    end

    assign o_in_ready       = (r_state == S_IDLE);
    assign o_out_valid      = (r_state == S_OUT);
    assign o_status         = r_status;
    assign o_physical_block = r_phys;
    assign o_extent_total   = TOTAL_W'(r_used);
    assign o_block_total    = r_sum;

    // input and output sides never open together
    a_one_side: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(o_in_ready && o_out_valid))
        else $error("input ready while a result is pending");

    // fill count stays within the table
    a_used_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_used <= CNT_W'(MAX_EXTENTS))
        else $error("extent count beyond table size");

    // a lookup transfer always starts a scan
    a_lookup_scan: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_xfer && (i_op == OP_LOOKUP)) |=> (r_state == S_SCAN))
        else $error("lookup did not start a scan");

    // scan step counter never runs past the row length
    a_scan_cnt: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SCAN) |-> (r_cnt <= CNT_W'(MAX_EXTENTS)))
        else $error("scan counter overran");

    // table contents only change on an input transfer
    a_state_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!in_xfer && $past(i_rst_n)) |=> ($stable(r_used) && $stable(r_sum)))
        else $error("table changed without a transfer");

endmodule

>>> rtl/core/emt_cell.sv
module emt_cell import emt_pkg::*; (
    input  logic   i_clk,
    input  logic   i_we,
    input  t_ext   i_wr,
    input  t_token i_tok,
    output t_token o_tok
);

    t_ext             r_ext;
    t_token           r_tok;
    t_token           n_tok;
    logic [BEF_W-1:0] after;
    logic             active;
    logic             hit;

    always_comb begin
        n_tok  = i_tok;
        after  = i_tok.passed + BEF_W'(r_ext.len);
        active = (i_tok.remaining != '0) && !i_tok.found;
        hit    = active && (OFS_W'(after) > i_tok.index);
        if (hit) begin
            n_tok.found = 1'b1;
            n_tok.phys  = r_ext.start + BLK_W'(i_tok.index - OFS_W'(i_tok.passed));
        end else if (active) begin
            n_tok.passed    = after;
            n_tok.remaining = i_tok.remaining - CNT_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_ext <= i_wr;
        end
        r_tok <= n_tok;
    end

    assign o_tok = r_tok;

endmodule

>>> bench/extent_map_check.sv
`timescale 1ns / 100ps

module extent_map_check import emt_pkg::*; (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_cfg_we,
    input  logic [SHIFT_W-1:0]  i_cfg_wdata,
    input  logic                i_in_valid,
    input  logic                i_in_ready,
    input  logic [OP_W-1:0]     i_op,
    input  logic [BLK_W-1:0]    i_start_block,
    input  logic [LEN_W-1:0]    i_run_length,
    input  logic [OFS_W-1:0]    i_byte_offset,
    input  logic                i_out_valid,
    input  logic                i_out_ready,
    input  logic [STATUS_W-1:0] i_status,
    input  logic [BLK_W-1:0]    i_physical_block,
    input  logic [TOTAL_W-1:0]  i_extent_total,
    input  logic [BLK_W-1:0]    i_block_total,
    output int                  o_error_count,
    output int                  o_pending
);

    localparam int REPORT_LIMIT = 10;

    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic [BLK_W-1:0]    phys;
        logic [TOTAL_W-1:0]  extents;
        logic [BLK_W-1:0]    blocks;
    } t_translation;

    // shadow extent list and block size
    logic [BLK_W-1:0]   map_start [MAX_EXTENTS];
    logic [LEN_W-1:0]   map_len   [MAX_EXTENTS];
    int unsigned        map_used;
    logic [BLK_W-1:0]   map_blocks;
    logic [SHIFT_W-1:0] map_shift;

    t_translation pending_translations [$];

    function automatic t_translation translate_item(
        input logic [OP_W-1:0]  op,
        input logic [BLK_W-1:0] start,
        input logic [LEN_W-1:0] len,
        input logic [OFS_W-1:0] ofs
    );
        t_translation     res;
        logic [BLK_W-1:0] tail_len;
        logic [BLK_W-1:0] tail_end;
        logic [LEN_W:0]   grown;
        logic [OFS_W-1:0] index;
        logic [63:0]      run_base;
        logic [63:0]      run_top;
        logic [63:0]      wide_phys;
        logic             done;
        res.status = ST_NONE;
        res.phys   = '0;
        done       = 1'b0;
        case (op)
            OP_APPEND: begin
                if (map_used > 0) begin
                    tail_len = BLK_W'(map_len[IDX_W'(map_used - 1)]);
                    tail_end = map_start[IDX_W'(map_used - 1)] + tail_len;
                    grown    = {1'b0, map_len[IDX_W'(map_used - 1)]} + {1'b0, len};
                    // merge only when contiguous and the length still fits
                    if (tail_end == start && !grown[LEN_W]) begin
                        map_len[IDX_W'(map_used - 1)] = grown[LEN_W-1:0];
                        map_blocks = map_blocks + BLK_W'(len);
                        res.status = ST_MERGED;
                        done       = 1'b1;
                    end
                end
                if (!done) begin
                    if (map_used >= MAX_EXTENTS) begin
                        res.status = ST_FULL;
                    end else begin
                        map_start[IDX_W'(map_used)] = start;
                        map_len[IDX_W'(map_used)]   = len;
                        map_used                    = map_used + 1;
                        map_blocks                  = map_blocks + BLK_W'(len);
                        res.status                  = ST_NEW;
                    end
                end
            end
            OP_LOOKUP: begin
                index    = ofs >> map_shift;
                run_base = '0;
                for (int i = 0; i < map_used; i++) begin
                    run_top = run_base + 64'(map_len[IDX_W'(i)]);
                    if (!done && run_top > 64'(index)) begin
                        wide_phys  = 64'(map_start[IDX_W'(i)]) + (64'(index) - run_base);
                        res.phys   = wide_phys[BLK_W-1:0];
                        res.status = ST_FOUND;
                        done       = 1'b1;
                    end
                    run_base = run_top;
                end
            end
            OP_CLEAR: begin
                map_used   = 0;
                map_blocks = '0;
            end
            default: begin
            end
        endcase
        res.extents = map_used[TOTAL_W-1:0];
        res.blocks  = map_blocks;
        return res;
    endfunction

    always @(posedge i_clk) begin : watch
        t_translation want;
        t_translation got;
        if (!i_rst_n) begin
            map_used      = 0;
            map_blocks    = '0;
            map_shift     = SHIFT_RESET;
            o_error_count = 0;
            pending_translations.delete();
        end else begin
            if (i_cfg_we)
                map_shift = i_cfg_wdata;
            if (i_in_valid && i_in_ready)
                pending_translations.push_back(translate_item(i_op, i_start_block,
                                                              i_run_length, i_byte_offset));
            if (i_out_valid && i_out_ready) begin
                got = {i_status, i_physical_block, i_extent_total, i_block_total};
                if (pending_translations.size() == 0) begin
                    if (o_error_count < REPORT_LIMIT)
                        $display("%0t: result transfer with nothing expected: status %0d",
                                 $realtime, i_status);
                    o_error_count++;
                end else begin
                    want = pending_translations.pop_front();
                    if (got.status !== want.status || got.phys !== want.phys ||
                        got.extents !== want.extents || got.blocks !== want.blocks) begin
                        if (o_error_count < REPORT_LIMIT)
                            $display({"%0t: mismatch status exp %0d got %0d, phys exp %h got %h,",
                                      " extents exp %0d got %0d, blocks exp %h got %h"},
                                     $realtime, want.status, got.status, want.phys, got.phys,
                                     want.extents, got.extents, want.blocks, got.blocks);
                        o_error_count++;
                    end
                end
            end
        end
        o_pending = pending_translations.size();
    end

endmodule

>>> bench/extent_map_translate_test.sv
`timescale 1ns / 100ps

module extent_map_translate_test;
    import emt_pkg::*;

    localparam int CLK_PERIOD    = 12;
    localparam int RESET_CYCLES  = 11;
    // a lookup walks the whole cell row, so allow its latency plus some margin
    localparam int SETTLE_CYCLES = MAX_EXTENTS + 16;
    // long receiver hold-off, applied in the third phase where neither side idles
    localparam int HOLD_PHASE    = 3;
    localparam int HOLD_CYCLES   = 400;
    localparam int TIMEOUT_NS    = 10_000_000;
    // op code the block does not know
    localparam logic [OP_W-1:0] OP_UNKNOWN = 2'd3;

    logic                i_clk         = 1'b0;
    logic                i_rst_n       = 1'b0;
    logic                i_cfg_we      = 1'b0;
    logic [SHIFT_W-1:0]  i_cfg_wdata   = SHIFT_RESET;
    logic                i_in_valid    = 1'b0;
    logic                o_in_ready;
    logic [OP_W-1:0]     i_op          = OP_APPEND;
    logic [BLK_W-1:0]    i_start_block = '0;
    logic [LEN_W-1:0]    i_run_length  = '0;
    logic [OFS_W-1:0]    i_byte_offset = '0;
    logic                o_out_valid;
    logic                i_out_ready   = 1'b0;
    logic [STATUS_W-1:0] o_status;
    logic [BLK_W-1:0]    o_physical_block;
    logic [TOTAL_W-1:0]  o_extent_total;
    logic [BLK_W-1:0]    o_block_total;

    int error_count;
    int pending;

    // idling profile, percent of cycles each side sits out
    int send_idle_pct = 20;
    int recv_idle_pct = 85;
    int phase_idx     = 0;
    logic hold_off    = 1'b0;

    // stimulus bookkeeping: a rough picture of the table, only used to aim
    // appends and lookups, never for checking
    logic [SHIFT_W-1:0] cur_shift  = SHIFT_RESET;
    logic [BLK_W-1:0]   seen_total = '0;
    logic [BLK_W-1:0]   last_end   = '0;
    int                 ext_guess  = 0;
    int                 sess_left  = 0;
    logic               sess_fill  = 1'b0;

    always #(CLK_PERIOD / 2) i_clk = ~i_clk;

    extent_map_translate u_dut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cfg_we         (i_cfg_we),
        .i_cfg_wdata      (i_cfg_wdata),
        .i_in_valid       (i_in_valid),
        .o_in_ready       (o_in_ready),
        .i_op             (i_op),
        .i_start_block    (i_start_block),
        .i_run_length     (i_run_length),
        .i_byte_offset    (i_byte_offset),
        .o_out_valid      (o_out_valid),
        .i_out_ready      (i_out_ready),
        .o_status         (o_status),
        .o_physical_block (o_physical_block),
        .o_extent_total   (o_extent_total),
        .o_block_total    (o_block_total)
    );

    extent_map_check u_check (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cfg_we         (i_cfg_we),
        .i_cfg_wdata      (i_cfg_wdata),
        .i_in_valid       (i_in_valid),
        .i_in_ready       (o_in_ready),
        .i_op             (i_op),
        .i_start_block    (i_start_block),
        .i_run_length     (i_run_length),
        .i_byte_offset    (i_byte_offset),
        .i_out_valid      (o_out_valid),
        .i_out_ready      (i_out_ready),
        .i_status         (o_status),
        .i_physical_block (o_physical_block),
        .i_extent_total   (o_extent_total),
        .i_block_total    (o_block_total),
        .o_error_count    (error_count),
        .o_pending        (pending)
    );

    // receiver: random ready at each falling edge, forced low during the hold-off
    always @(negedge i_clk) begin
        if (hold_off)
            i_out_ready = 1'b0;
        else
            i_out_ready = ($urandom_range(99) >= recv_idle_pct);
    end

    // keep the latest block total seen on the output, used to aim lookups
    always @(posedge i_clk) begin
        if (o_out_valid && i_out_ready)
            seen_total <= o_block_total;
    end

    // long hold-off: the sender keeps offering, so the block fills and stalls
    initial begin
        wait (phase_idx == HOLD_PHASE);
        repeat (50) @(posedge i_clk);
        hold_off = 1'b1;
        repeat (HOLD_CYCLES) @(posedge i_clk);
        hold_off = 1'b0;
    end

    // one input transfer; entered and left at a falling edge, valid stays
    // high on exit so back-to-back items never drop it
    task automatic send_item(
        input logic [OP_W-1:0]  op,
        input logic [BLK_W-1:0] start,
        input logic [LEN_W-1:0] len,
        input logic [OFS_W-1:0] ofs
    );
        while ($urandom_range(99) < send_idle_pct) begin
            i_in_valid = 1'b0;
            @(negedge i_clk);
        end
        i_in_valid    = 1'b1;
        i_op          = op;
        i_start_block = start;
        i_run_length  = len;
        i_byte_offset = ofs;
        do
            @(posedge i_clk);
        while (!o_in_ready);
        @(negedge i_clk);
    endtask

    // drop valid, wait for every result, then let a full lookup drain
    task automatic settle();
        i_in_valid = 1'b0;
        while (pending != 0)
            @(negedge i_clk);
        repeat (SETTLE_CYCLES) @(negedge i_clk);
    endtask

    task automatic directed_items();
        // lookup on an empty table
        send_item(OP_LOOKUP, '0, 24'd1, '0);
        // first append into an empty table, then a contiguous run that merges
        send_item(OP_APPEND, 32'd100, 24'd10, '0);
        send_item(OP_APPEND, 32'd110, 24'd5, '0);
        // first block, last byte of the last block, and the index equal to the sum
        send_item(OP_LOOKUP, '0, '0, 40'd0);
        send_item(OP_LOOKUP, '0, '0, (40'd14 << SHIFT_RESET) | 40'hFFF);
        send_item(OP_LOOKUP, '0, '0, 40'd15 << SHIFT_RESET);
        // extent ending exactly on the 32-bit wrap, then a merge across it
        send_item(OP_APPEND, 32'hFFFF_FFF0, 24'd16, '0);
        send_item(OP_APPEND, 32'd0, 24'd3, '0);
        // physical block of the lookup wraps past zero
        send_item(OP_LOOKUP, '0, '0, 40'd33 << SHIFT_RESET);
        // zero-length extent, skipped by a lookup
        send_item(OP_APPEND, 32'd200, 24'd0, '0);
        send_item(OP_LOOKUP, '0, '0, 40'd34 << SHIFT_RESET);
        // merge into the zero-length extent, then a merge that would overflow
        send_item(OP_APPEND, 32'd200, 24'hFF_FFFF, '0);
        send_item(OP_APPEND, 32'd200 + 32'hFF_FFFF, 24'd1, '0);
        send_item(OP_LOOKUP, '0, '0, 40'd34 << SHIFT_RESET);
        // unknown op with every field at its top
        send_item(OP_UNKNOWN, '1, '1, '1);
        // largest offset misses
        send_item(OP_LOOKUP, '0, '0, '1);
        // clear, then lookup on the cleared table
        send_item(OP_CLEAR, '1, '1, '0);
        send_item(OP_LOOKUP, '0, '0, '0);
        // largest start and length, lookup near the end of it
        send_item(OP_APPEND, '1, '1, '0);
        send_item(OP_LOOKUP, '0, '0, 40'hFF_FFFE << SHIFT_RESET);
    endtask

    // random item inside a session: a session opens with a clear, then mostly
    // appends and lookups; fill sessions run long enough to reach a full table
    task automatic random_item();
        logic [OP_W-1:0]  op;
        logic [BLK_W-1:0] start;
        logic [LEN_W-1:0] len;
        logic [OFS_W-1:0] ofs;
        logic [63:0]      span;
        logic [63:0]      idx;
        logic [63:0]      wide;
        int               pick;
        start = $urandom;
        len   = LEN_W'($urandom);
        ofs   = OFS_W'({$urandom, $urandom});
        if (sess_left == 0) begin
            op        = OP_CLEAR;
            ext_guess = 0;
            sess_fill = ($urandom_range(99) < 30);
            sess_left = sess_fill ? $urandom_range(90, 66) : $urandom_range(30, 4);
        end else begin
            sess_left--;
            pick = $urandom_range(99);
            if (pick < 3) begin
                op = OP_UNKNOWN;
            end else if (pick < 5) begin
                // stray clear in the middle of a session
                op        = OP_CLEAR;
                ext_guess = 0;
            end else if (pick < (sess_fill ? 80 : 55)) begin
                op   = OP_APPEND;
                pick = $urandom_range(99);
                if (pick < 10)
                    len = '0;
                else if (pick < 15)
                    len = {LEN_W{1'b1}} - LEN_W'($urandom_range(3));
                else if (pick < 85)
                    len = LEN_W'($urandom_range(64, 1));
                // contiguous runs merge; in fill sessions they also hit a full table
                if ($urandom_range(99) < (sess_fill ? 15 : 50))
                    start = last_end;
                if (start == last_end && ext_guess > 0) begin
                    last_end = start + BLK_W'(len);
                end else if (ext_guess < MAX_EXTENTS) begin
                    ext_guess++;
                    last_end = start + BLK_W'(len);
                end
            end else begin
                op = OP_LOOKUP;
                // most lookups aim near the held blocks, the rest take any offset
                if ($urandom_range(99) < 60) begin
                    span = {32'd0, seen_total} + 64'd2;
                    idx  = {$urandom, $urandom} % span;
                    wide = (idx << cur_shift) |
                           ({$urandom, $urandom} & ((64'd1 << cur_shift) - 64'd1));
                    ofs  = wide[OFS_W-1:0];
                end
            end
        end
        send_item(op, start, len, ofs);
    endtask

    // reconfigure while idle, set the idling profile, then run random items
    task automatic run_phase(
        input logic [SHIFT_W-1:0] shift,
        input int                 items,
        input int                 send_pct,
        input int                 recv_pct
    );
        settle();
        i_cfg_we      = 1'b1;
        i_cfg_wdata   = shift;
        cur_shift     = shift;
        send_idle_pct = send_pct;
        recv_idle_pct = recv_pct;
        @(negedge i_clk);
        i_cfg_we  = 1'b0;
        phase_idx = phase_idx + 1;
        repeat (items) random_item();
    endtask

    initial begin
        repeat (RESET_CYCLES) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // directed items at the reset block size
        directed_items();

        // sender idles lightly, receiver heavily, block size of 2^6 bytes
        run_phase(5'd6, 500, 20, 85);
        // the other way round, block size of 2^20 bytes
        run_phase(5'd20, 500, 85, 20);
        // no idling from here on; byte-granular offsets, hold-off lands here
        run_phase(5'd0, 250, 0, 0);
        // top of the 5-bit range
        run_phase(5'd31, 100, 0, 0);
        run_phase(5'd9, 150, 0, 0);

        settle();
        if (error_count == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

    // watchdog
    initial begin
        #(TIMEOUT_NS);
        $display("DONE: errors detected");
        $finish;
    end

endmodule
